[sv/mqkr_pkg.sv]
// Package of the message queue with keyed removal.
// Holds the request and status codes, the cell command and the result record.
// It depends on nothing; every other file of the block uses it.
package mqkr_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 32;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_POP    = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_FLUSH  = 3'd4;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_QUEUED   = 3'd2;
  localparam logic [2:0] STAT_BADPOS   = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;
  localparam logic [2:0] STAT_EMPTY    = 3'd5;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_INSERT,
    CMD_POP,
    CMD_MATCH,
    CMD_SWEEP,
    CMD_REMOVE
  } cell_cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_REMOVE
  } state_e;

  typedef struct packed {
    logic [4:0]  entry_count;
    logic        head_valid;
    logic [31:0] head_id;
    logic [2:0]  status;
  } result_t;

endpackage

[sv/mqkr_cell.sv]
// One storage cell of the queue chain: holds one id and one match-prefix bit.
// It loads the key or a neighbour's id as the broadcast command dictates.
// Depends on mqkr_pkg.
module mqkr_cell #(
  parameter int ID_WIDTH = mqkr_pkg::ID_WIDTH_DEF,
  parameter int XW       = 8,
  parameter int IDX      = 0
) (
  input  logic                clk_i,
  input  mqkr_pkg::cell_cmd_e cmd_i,
  input  logic [ID_WIDTH-1:0] key_i,
  input  logic [XW-1:0]       count_i,
  input  logic [XW-1:0]       ins_i,
  input  logic [ID_WIDTH-1:0] left_id_i,
  input  logic [ID_WIDTH-1:0] right_id_i,
  input  logic                pre_i,
  output logic [ID_WIDTH-1:0] id_o,
  output logic [ID_WIDTH-1:0] nxt_o,
  output logic                pre_o
);

  localparam logic [XW-1:0] MyIdx = XW'(IDX);

  logic [ID_WIDTH-1:0] id_q, id_d;
  logic                pre_q, pre_d;
  logic                occ;

  assign occ = MyIdx < count_i;

  always_comb begin
    id_d  = id_q;
    pre_d = pre_q;
    unique case (cmd_i)
      mqkr_pkg::CMD_APPEND: begin
        if (MyIdx == count_i) id_d = key_i;
      end
      mqkr_pkg::CMD_INSERT: begin
        if (MyIdx == ins_i) id_d = key_i;
        else if (MyIdx > ins_i) id_d = left_id_i;
      end
      mqkr_pkg::CMD_POP: begin
        id_d = right_id_i;
      end
      mqkr_pkg::CMD_MATCH: begin
        pre_d = occ && (id_q == key_i);
      end
      mqkr_pkg::CMD_SWEEP: begin
        pre_d = pre_q | pre_i;
      end
      mqkr_pkg::CMD_REMOVE: begin
        if (pre_q) id_d = right_id_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    pre_q <= pre_d;
  end

  assign id_o  = id_q;
  assign nxt_o = id_d;
  assign pre_o = pre_q;

endmodule

[sv/message_queue_with_keyed_removal.sv]
// Top level of the message queue with keyed removal: a chain of id cells,
// the fill count, the request sequencer and a two-entry result buffer.
// Depends on mqkr_pkg and mqkr_cell.
//
// Requests arrive on the s_axis channel and one result per request leaves on
// the m_axis channel. A request is taken when s_axis_tvalid and s_axis_tready
// are both high. Append, insert, pop, flush and unknown request types update
// the chain in the cycle of the transfer, and their result is registered
// into the result buffer. Remove by id runs in three steps: every cell
// compares its id with the key, the match bit ripples along the chain in the
// sweep state, and in the remove state the cells at and behind the first
// match take their right neighbour's id.
// Results pass through an output register backed by a skid entry, so one
// further request is taken while a result waits for the receiver; after that
// s_axis_tready stays low until the receiver takes a result.
// Reset empties the queue and the result buffer; the stored ids are not
// cleared and are never shown before they are written.
module message_queue_with_keyed_removal #(
  parameter int DEPTH    = mqkr_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = mqkr_pkg::ID_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // msg_id [31:0], position [35:32], already_queued [36], zero fill [39:37]
  input  logic [39:0] s_axis_tdata,
  // req_type [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [2:0], head_id [34:3], head_valid [35], entry_count [40:36],
  // zero fill [47:41]
  output logic [47:0] m_axis_tdata
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int XW   = CW + 5;
  localparam int SW_W = $clog2(DEPTH);
  localparam logic [SW_W-1:0] SweepLast = SW_W'(DEPTH - 2);
  localparam logic [CW-1:0]   CountFull = CW'(DEPTH);

  logic [ID_WIDTH-1:0] ids  [DEPTH];
  logic [ID_WIDTH-1:0] nxts [DEPTH];
  logic                pres [DEPTH];

  mqkr_pkg::state_e    state_q, state_d;
  mqkr_pkg::cell_cmd_e cmd;
  logic [CW-1:0]       count_q, count_d;
  logic [SW_W-1:0]     sw_q, sw_d;
  logic                push;
  logic [2:0]          status;
  mqkr_pkg::result_t   res, out_q, skid_q;
  logic                out_v_q, skid_v_q;
  logic                accept, o_free;
  logic [ID_WIDTH-1:0] key;
  logic [XW-1:0]       cnt_x, pos_x, ins_x;
  logic [2:0]          req;
  logic                queued;

  assign req    = s_axis_tuser;
  assign queued = s_axis_tdata[36];
  assign key    = ID_WIDTH'(s_axis_tdata[31:0]);
  assign cnt_x  = XW'(count_q);
  assign pos_x  = XW'(s_axis_tdata[35:32]);
  assign ins_x  = pos_x + XW'(1);

  assign s_axis_tready = (state_q == mqkr_pkg::S_IDLE) && !skid_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] left_id, right_id;
    logic                pre_in;
    if (i == 0) begin : g_first
      assign left_id = '0;
      assign pre_in  = 1'b0;
    end else begin : g_mid
      assign left_id = ids[i-1];
      assign pre_in  = pres[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_id = '0;
    end else begin : g_inner
      assign right_id = ids[i+1];
    end
    mqkr_cell #(
      .ID_WIDTH (ID_WIDTH),
      .XW       (XW),
      .IDX      (i)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .key_i      (key),
      .count_i    (cnt_x),
      .ins_i      (ins_x),
      .left_id_i  (left_id),
      .right_id_i (right_id),
      .pre_i      (pre_in),
      .id_o       (ids[i]),
      .nxt_o      (nxts[i]),
      .pre_o      (pres[i])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sw_d    = sw_q;
    cmd     = mqkr_pkg::CMD_HOLD;
    push    = 1'b0;
    status  = mqkr_pkg::STAT_OK;
    unique case (state_q)
      mqkr_pkg::S_IDLE: begin
        if (accept) begin
          push = 1'b1;
          unique case (req)
            mqkr_pkg::REQ_APPEND: begin
              if (queued) status = mqkr_pkg::STAT_QUEUED;
              else if (count_q == CountFull) status = mqkr_pkg::STAT_FULL;
              else begin
                cmd     = mqkr_pkg::CMD_APPEND;
                count_d = count_q + CW'(1);
              end
            end
            mqkr_pkg::REQ_INSERT: begin
              if (pos_x >= cnt_x) status = mqkr_pkg::STAT_BADPOS;
              else if (queued) status = mqkr_pkg::STAT_QUEUED;
              else if (count_q == CountFull) status = mqkr_pkg::STAT_FULL;
              else begin
                cmd     = mqkr_pkg::CMD_INSERT;
                count_d = count_q + CW'(1);
              end
            end
            mqkr_pkg::REQ_POP: begin
              if (count_q == '0) status = mqkr_pkg::STAT_EMPTY;
              else begin
                cmd     = mqkr_pkg::CMD_POP;
                count_d = count_q - CW'(1);
              end
            end
            mqkr_pkg::REQ_REMOVE: begin
              push    = 1'b0;
              cmd     = mqkr_pkg::CMD_MATCH;
              sw_d    = '0;
              state_d = mqkr_pkg::S_SWEEP;
            end
            mqkr_pkg::REQ_FLUSH: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      mqkr_pkg::S_SWEEP: begin
        cmd  = mqkr_pkg::CMD_SWEEP;
        sw_d = sw_q + SW_W'(1);
        if (sw_q == SweepLast) state_d = mqkr_pkg::S_REMOVE;
      end
      mqkr_pkg::S_REMOVE: begin
        cmd     = mqkr_pkg::CMD_REMOVE;
        push    = 1'b1;
        state_d = mqkr_pkg::S_IDLE;
        if (pres[DEPTH-1]) count_d = count_q - CW'(1);
        else status = mqkr_pkg::STAT_NOTFOUND;
      end
      default: begin
        state_d = mqkr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status      = status;
    res.head_valid  = count_d != '0;
    res.head_id     = res.head_valid ? 32'(nxts[0]) : 32'd0;
    res.entry_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mqkr_pkg::S_IDLE;
      count_q <= '0;
      sw_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sw_q    <= sw_d;
    end
  end

  assign o_free = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (o_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= push;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free) begin
      if (skid_v_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q  <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_q};

endmodule

[sv/mqkr_checker.sv]
// Port-level checks for the message queue with keyed removal, and the bind
// that attaches them to the top level. Depends on mqkr_pkg.
module mqkr_checker #(
  parameter int DEPTH = mqkr_pkg::DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  localparam logic [4:0] CountFull = 5'(DEPTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result changed while the receiver stalled.");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[35] |-> m_axis_tdata[34:3] == 32'd0)
    else $error("Head id is not zero for an empty queue.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == mqkr_pkg::STAT_FULL
      |-> m_axis_tdata[40:36] == CountFull && m_axis_tdata[35])
    else $error("Full status reported without a full queue.");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == mqkr_pkg::STAT_EMPTY
      |-> m_axis_tdata[40:36] == 5'd0 && !m_axis_tdata[35])
    else $error("Empty status reported for a queue that holds entries.");

endmodule

bind message_queue_with_keyed_removal mqkr_checker #(.DEPTH(DEPTH)) u_mqkr_checker (.*);

[tb/message_queue_with_keyed_removal_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the message queue with keyed removal: request transfers go
// in with random gaps, a queue model of its own predicts every result, and each result
// is checked field by field. Depends on mqkr_pkg and message_queue_with_keyed_removal.
module message_queue_with_keyed_removal_tb;

  localparam int QUEUE_DEPTH   = mqkr_pkg::DEPTH_DEF;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 3 * (QUEUE_DEPTH + 1);

  localparam logic [2:0] REQ_SPARE_5 = 3'd5;
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  logic [31:0]       held_ids[$];
  mqkr_pkg::result_t pending_results[$];
  int                errors      = 0;
  int                peak_fill   = 0;
  int                checked     = 0;
  int                idle_cycles = 0;
  int                sink_hold   = 0;
  bit                src_steady  = 1'b0;
  bit                sink_steady = 1'b0;
  int                req_seen[8];
  int                status_seen[8];

  message_queue_with_keyed_removal i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 9) < 3) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic mqkr_pkg::result_t apply_queue_request(input logic [2:0] req,
                                                            input logic [31:0] id,
                                                            input logic [3:0] pos,
                                                            input logic queued);
    mqkr_pkg::result_t r;
    int                hit;
    r.status = mqkr_pkg::STAT_OK;
    hit = -1;
    case (req)
      mqkr_pkg::REQ_APPEND: begin
        if (queued) r.status = mqkr_pkg::STAT_QUEUED;
        else if (held_ids.size() >= QUEUE_DEPTH) r.status = mqkr_pkg::STAT_FULL;
        else held_ids.push_back(id);
      end
      mqkr_pkg::REQ_INSERT: begin
        if (int'(pos) >= held_ids.size()) r.status = mqkr_pkg::STAT_BADPOS;
        else if (queued) r.status = mqkr_pkg::STAT_QUEUED;
        else if (held_ids.size() >= QUEUE_DEPTH) r.status = mqkr_pkg::STAT_FULL;
        else held_ids.insert(int'(pos) + 1, id);
      end
      mqkr_pkg::REQ_POP: begin
        if (held_ids.size() == 0) r.status = mqkr_pkg::STAT_EMPTY;
        else void'(held_ids.pop_front());
      end
      mqkr_pkg::REQ_REMOVE: begin
        foreach (held_ids[i]) begin
          if (hit < 0 && held_ids[i] == id) hit = i;
        end
        if (hit < 0) r.status = mqkr_pkg::STAT_NOTFOUND;
        else held_ids.delete(hit);
      end
      mqkr_pkg::REQ_FLUSH: begin
        held_ids.delete();
      end
      default: begin
      end
    endcase
    r.head_valid  = (held_ids.size() != 0);
    r.head_id     = r.head_valid ? held_ids[0] : 32'd0;
    r.entry_count = 5'(held_ids.size());
    if (held_ids.size() > peak_fill) peak_fill = held_ids.size();
    return r;
  endfunction

  task automatic send_request(input logic [2:0] req, input logic [31:0] id,
                              input logic [3:0] pos, input logic queued);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, queued, pos, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_queue_request(req, id, pos, queued));
    req_seen[req]++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    errors++;
  endtask

  // The sink samples each result transfer and compares it with the oldest prediction.
  always @(posedge clk_i) begin : check_result
    mqkr_pkg::result_t got;
    mqkr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[40:0];
      status_seen[got.status]++;
      if (m_axis_tdata[47:41] != 7'd0)
        flag_mismatch("zero fill", 32'd0, 32'(m_axis_tdata[47:41]));
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.status != want.status)
          flag_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.head_id != want.head_id) flag_mismatch("head_id", want.head_id, got.head_id);
        if (got.head_valid != want.head_valid)
          flag_mismatch("head_valid", 32'(want.head_valid), 32'(got.head_valid));
        if (got.entry_count != want.entry_count)
          flag_mismatch("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      end
    end
  end

  // The receiver stalls at random and, on request, holds off for a counted stretch.
  initial begin : drive_sink
    int gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end
      gap = sink_steady ? 0 : pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, pending_results.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_basic_requests();
    send_request(mqkr_pkg::REQ_POP, 32'd0, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_REMOVE, 32'd0, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_INSERT, 32'h0000_0042, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_APPEND, 32'h1111_1111, 4'd0, 1'b1);
    send_request(mqkr_pkg::REQ_APPEND, 32'h0000_0000, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_APPEND, 32'hFFFF_FFFF, 4'd15, 1'b0);
    send_request(mqkr_pkg::REQ_APPEND, 32'hA5A5_5A5A, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_INSERT, 32'h0000_1234, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_INSERT, 32'h5A5A_A5A5, 4'd15, 1'b1);
    send_request(mqkr_pkg::REQ_INSERT, 32'h0BAD_CAFE, 4'd1, 1'b1);
    send_request(REQ_SPARE_5, $urandom, 4'd3, 1'b1);
    send_request(REQ_SPARE_6, $urandom, 4'd9, 1'b0);
    send_request(REQ_SPARE_7, $urandom, 4'd15, 1'b1);
    send_request(mqkr_pkg::REQ_APPEND, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_REMOVE, 32'hDEAD_BEEF, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_POP, 32'h0000_0000, 4'd7, 1'b1);
    send_request(mqkr_pkg::REQ_REMOVE, held_ids[0], 4'd0, 1'b1);
    send_request(mqkr_pkg::REQ_INSERT, 32'h7777_0001, 4'(held_ids.size() - 1), 1'b0);
    send_request(mqkr_pkg::REQ_FLUSH, $urandom, 4'd5, 1'b1);
    send_request(mqkr_pkg::REQ_FLUSH, 32'd0, 4'd0, 1'b0);
  endtask

  task automatic test_full_queue();
    repeat (QUEUE_DEPTH) send_request(mqkr_pkg::REQ_APPEND, pick_id(), 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_APPEND, $urandom, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_APPEND, $urandom, 4'd0, 1'b1);
    send_request(mqkr_pkg::REQ_INSERT, $urandom, 4'd15, 1'b0);
    send_request(mqkr_pkg::REQ_INSERT, $urandom, 4'd15, 1'b1);
    send_request(mqkr_pkg::REQ_REMOVE, held_ids[QUEUE_DEPTH - 1], 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_INSERT, 32'hFFFF_0000, 4'd14, 1'b0);
    send_request(mqkr_pkg::REQ_REMOVE, held_ids[0], 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_POP, 32'd0, 4'd0, 1'b0);
    send_request(mqkr_pkg::REQ_FLUSH, 32'd0, 4'd0, 1'b0);
  endtask

  task automatic test_output_stall();
    int k;
    src_steady = 1'b1;
    sink_hold  = HOLD_CYCLES;
    for (k = 0; k < 20; k++)
      send_request((k % 3 == 2) ? mqkr_pkg::REQ_REMOVE : mqkr_pkg::REQ_APPEND, pick_id(),
                   4'(k), 1'b0);
    wait_drained();
    sink_steady = 1'b1;
    for (k = 0; k < 30; k++)
      send_request((k % 4 == 3) ? mqkr_pkg::REQ_POP : mqkr_pkg::REQ_APPEND, pick_id(),
                   4'd0, 1'b0);
    wait_drained();
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Mostly well-formed traffic that drifts towards a full queue and removes ids that
  // are really queued; the rest is noise over every field, spare codes included.
  task automatic test_random_traffic(input int target);
    int          sent;
    int          burst;
    int          roll;
    int          fill;
    bit          tidy;
    logic [2:0]  req;
    logic [31:0] id;
    logic [3:0]  pos;
    logic        queued;
    sent = 0;
    while (sent < target) begin
      burst       = $urandom_range(4, 40);
      tidy        = ($urandom_range(0, 99) < 75);
      src_steady  = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      repeat (burst) begin
        fill   = held_ids.size();
        id     = pick_id();
        pos    = 4'($urandom_range(0, 15));
        queued = ($urandom_range(0, 9) == 0);
        if (tidy) begin
          roll = $urandom_range(0, 99);
          if (roll < 35) begin
            req = mqkr_pkg::REQ_APPEND;
          end else if (roll < 55) begin
            req = mqkr_pkg::REQ_INSERT;
            if (fill > 0) pos = 4'($urandom_range(0, fill - 1));
          end else if (roll < 80) begin
            req = mqkr_pkg::REQ_REMOVE;
            if (fill > 0 && $urandom_range(0, 9) < 8) id = held_ids[$urandom_range(0, fill - 1)];
          end else if (roll < 97) begin
            req = mqkr_pkg::REQ_POP;
          end else begin
            req = mqkr_pkg::REQ_FLUSH;
          end
        end else begin
          req    = 3'($urandom_range(0, 7));
          id     = $urandom;
          queued = 1'($urandom_range(0, 1));
        end
        send_request(req, id, pos, queued);
        sent++;
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_requests();
    wait_drained();
    test_full_queue();
    wait_drained();
    test_output_stall();
    test_random_traffic(1500);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Run covered %0d append, %0d insert, %0d pop, %0d remove, %0d flush and %0d spare",
             req_seen[mqkr_pkg::REQ_APPEND], req_seen[mqkr_pkg::REQ_INSERT],
             req_seen[mqkr_pkg::REQ_POP], req_seen[mqkr_pkg::REQ_REMOVE],
             req_seen[mqkr_pkg::REQ_FLUSH],
             req_seen[REQ_SPARE_5] + req_seen[REQ_SPARE_6] + req_seen[REQ_SPARE_7]);
    $display({"%0d results checked (ok %0d, full %0d, queued %0d, bad position %0d, ",
              "not found %0d, empty %0d), peak fill %0d, %0d mismatches"},
             checked, status_seen[mqkr_pkg::STAT_OK], status_seen[mqkr_pkg::STAT_FULL],
             status_seen[mqkr_pkg::STAT_QUEUED], status_seen[mqkr_pkg::STAT_BADPOS],
             status_seen[mqkr_pkg::STAT_NOTFOUND], status_seen[mqkr_pkg::STAT_EMPTY],
             peak_fill, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/mqkr_pkg.sv
sv/mqkr_cell.sv
sv/message_queue_with_keyed_removal.sv
sv/mqkr_checker.sv
tb/message_queue_with_keyed_removal_tb.sv
